>>> sv/bsab_pkg.sv
// shared types, constants and helpers for the bilinear sample and blend core
package bsab_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned PixW   = 32;
  localparam int unsigned FracW  = 8;
  localparam int unsigned NChan  = 4;
  localparam int unsigned AlphaCh = 3;
  localparam int unsigned InW    = 4 * PixW + 2 * FracW + PixW;
  localparam logic [ChanW-1:0] AlphaReset = 8'd255;
  localparam logic [ChanW-1:0] AlphaMax   = 8'd255;
  localparam logic [FracW:0]   FracOne    = 9'd256;

  typedef logic [ChanW-1:0] chan_t;

  typedef struct packed {
    logic first;
    logic second;
  } stage_en_t;

  // floor(x / 255) for x up to 255 * 255
  function automatic chan_t div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

endpackage

>>> sv/bsab_lane.sv
// one colour channel lane: two-stage bilinear interpolation
module bsab_lane (
  input  logic                           clk_i,
  input  bsab_pkg::stage_en_t            en_i,
  input  bsab_pkg::chan_t                tl_i,
  input  bsab_pkg::chan_t                tr_i,
  input  bsab_pkg::chan_t                bl_i,
  input  bsab_pkg::chan_t                br_i,
  input  logic [bsab_pkg::FracW-1:0]     fx_i,
  input  logic [bsab_pkg::FracW-1:0]     fy_i,
  output bsab_pkg::chan_t                s_o
);

  logic [bsab_pkg::FracW:0] wy_inv, wx_inv;
  logic [16:0]              top_sum, bot_sum;
  logic [15:0]              top_d, top_q, bot_d, bot_q;
  logic [bsab_pkg::FracW-1:0] fx_q;
  logic [24:0]              h_sum;
  bsab_pkg::chan_t          s_d, s_q;

  // vertical pass
  always_comb begin
    wy_inv  = bsab_pkg::FracOne - {1'b0, fy_i};
    top_sum = 17'(tl_i * wy_inv) + 17'(bl_i * fy_i);
    bot_sum = 17'(tr_i * wy_inv) + 17'(br_i * fy_i);
    top_d   = top_sum[15:0];
    bot_d   = bot_sum[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.first) begin
      top_q <= top_d;
      bot_q <= bot_d;
      fx_q  <= fx_i;
    end
  end

  // horizontal pass, truncated by 16
  always_comb begin
    wx_inv = bsab_pkg::FracOne - {1'b0, fx_q};
    h_sum  = 25'(top_q * wx_inv) + 25'(bot_q * fx_q);
    s_d    = h_sum[23:16];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.second) begin
      s_q <= s_d;
    end
  end

  assign s_o = s_q;

endmodule

>>> sv/bsab_merge.sv
// merge stage: effective alpha, colour blend and alpha max
module bsab_merge (
  input  logic                              clk_i,
  input  bsab_pkg::stage_en_t               en_i,
  input  bsab_pkg::chan_t                   ga_i,
  input  bsab_pkg::chan_t [bsab_pkg::NChan-1:0] s_i,
  input  logic [bsab_pkg::PixW-1:0]         dest_i,
  output logic [bsab_pkg::PixW-1:0]         pix_o
);

  logic [15:0]                 a_prod;
  bsab_pkg::chan_t             a_d, a_q, na;
  bsab_pkg::chan_t [2:0]       s_q;
  logic [bsab_pkg::PixW-1:0]   dest_q;
  logic [bsab_pkg::PixW-1:0]   pix_d, pix_q;
  logic [16:0]                 mix;
  bsab_pkg::chan_t             da;

  always_comb begin
    a_prod = 16'(s_i[bsab_pkg::AlphaCh] * ga_i);
    a_d    = bsab_pkg::div255(a_prod);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.first) begin
      a_q    <= a_d;
      s_q    <= s_i[2:0];
      dest_q <= dest_i;
    end
  end

  always_comb begin
    na    = bsab_pkg::AlphaMax - a_q;
    pix_d = '0;
    mix   = '0;
    for (int k = 0; k < 3; k++) begin
      mix = 17'(s_q[k] * a_q) + 17'(dest_q[8*k +: 8] * na);
      pix_d[8*k +: 8] = bsab_pkg::div255(mix[15:0]);
    end
    da = dest_q[31:24];
    pix_d[31:24] = (da > a_q) ? da : a_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.second) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule

>>> sv/bilinear_sample_alpha_blend_core.sv
// top level of the bilinear sample and alpha blend core
// usage:
//   slave stream s_axis carries one destination pixel job per transfer:
//   four source pixels, x and y fractions and the current destination pixel.
//   master stream m_axis returns the blended destination pixel.
//   cfg channel writes the 8-bit global alpha; write only while idle.
// pipeline: each input transfer passes through two interpolation stages in the
//   channel lanes, then the alpha stage and the blend stage, to output valid.
// throughput: one pixel per cycle while m_axis_tready is high; each stage has a
//   valid bit and advances when the next is empty or moving, so bubbles close up.
// stall: when m_axis_tready is low the output register holds; upstream stages
//   keep filling until all four are full, then s_axis_tready drops.
// reset: pipeline emptied, global alpha returns to 255.
module bilinear_sample_alpha_blend_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // top_left, top_right, bottom_left, bottom_right, frac_x, frac_y, dest_pixel
  input  logic [bsab_pkg::InW-1:0]     s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // blended_pixel
  output logic [bsab_pkg::PixW-1:0]    m_axis_tdata,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  bsab_pkg::chan_t              cfg_data_i
);

  logic [31:0] tl, tr, bl, br, dest;
  logic [7:0]  fx, fy;
  bsab_pkg::chan_t ga_q;
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  bsab_pkg::stage_en_t lane_en, merge_en;
  logic [31:0] dest1_q, dest2_q;
  bsab_pkg::chan_t [bsab_pkg::NChan-1:0] s;

  assign tl   = s_axis_tdata[31:0];
  assign tr   = s_axis_tdata[63:32];
  assign bl   = s_axis_tdata[95:64];
  assign br   = s_axis_tdata[127:96];
  assign fx   = s_axis_tdata[135:128];
  assign fy   = s_axis_tdata[143:136];
  assign dest = s_axis_tdata[175:144];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ga_q <= bsab_pkg::AlphaReset;
    end else if (cfg_valid_i) begin
      ga_q <= cfg_data_i;
    end
  end

  // per-stage ready chain
  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  assign lane_en.first   = rdy1 && s_axis_tvalid;
  assign lane_en.second  = rdy2 && v1_q;
  assign merge_en.first  = rdy3 && v2_q;
  assign merge_en.second = rdy4 && v3_q;

  always_ff @(posedge clk_i) begin
    if (lane_en.first)  dest1_q <= dest;
    if (lane_en.second) dest2_q <= dest1_q;
  end

  for (genvar k = 0; k < bsab_pkg::NChan; k++) begin : g_lane
    bsab_lane u_lane (
      .clk_i (clk_i),
      .en_i  (lane_en),
      .tl_i  (tl[8*k +: 8]),
      .tr_i  (tr[8*k +: 8]),
      .bl_i  (bl[8*k +: 8]),
      .br_i  (br[8*k +: 8]),
      .fx_i  (fx),
      .fy_i  (fy),
      .s_o   (s[k])
    );
  end

  bsab_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (merge_en),
    .ga_i   (ga_q),
    .s_i    (s),
    .dest_i (dest2_q),
    .pix_o  (m_axis_tdata)
  );

  assign m_axis_tvalid = v4_q;

  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  a_transfer_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v1_q)
    else $error("accepted transfer lost in first stage");

  a_stage1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !rdy2 |=> v1_q)
    else $error("first stage dropped a stalled item");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !v3_q |=> !m_axis_tvalid)
    else $error("output repeated after transfer");

endmodule
